### sv/lhv_pkg.sv
// ----------------------------------------------------------------------------
// lhv_pkg
// Widths, limits and controller states shared by the landmark hash index.
// ----------------------------------------------------------------------------
package lhv_pkg;

    localparam int KEY_BITS    = 18;
    localparam int BLK_BITS    = 14;
    localparam int SLOT_BITS   = 3;
    localparam int OFS_BITS    = 14;
    localparam int ID_BITS     = 6;
    localparam int CNT_BITS    = 17;
    localparam int VOTE_BITS   = 15;
    localparam int VADDR_BITS  = ID_BITS + OFS_BITS;
    localparam int VAL_BITS    = ID_BITS + OFS_BITS;
    localparam int IN_BITS     = 40;
    localparam int OUT_BITS    = 40;

    localparam logic [CNT_BITS-1:0]  ENTRY_MAX   = 17'h1FFFF;
    localparam logic [VOTE_BITS-1:0] COUNT_MAX   = 15'h7FFF;
    localparam logic [14:0]          MAXB_RESET  = 15'd16384;
    localparam logic [6:0]           SONGS_RESET = 7'd64;
    localparam logic [6:0]           SONGS_MAX   = 7'd64;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_VOTE   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_REPORT = 2'd3;

    localparam logic CFG_MAX_BLOCKS = 1'b0;
    localparam logic CFG_SONG_COUNT = 1'b1;

    typedef enum logic [9:0] {
        S_INIT   = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_KRD    = 10'b0000000100,
        S_VRD    = 10'b0000001000,
        S_VQ     = 10'b0000010000,
        S_VUP    = 10'b0000100000,
        S_CLR    = 10'b0001000000,
        S_RPT    = 10'b0010000000,
        S_RDRAIN = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } t_state;

endpackage

### sv/lhv_ram.sv
// ----------------------------------------------------------------------------
// lhv_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lhv_ram #(
    parameter int AW = 8,
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [(2**AW)-1:0];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/landmark_hash_vote_index_top.sv
// ----------------------------------------------------------------------------
// landmark_hash_vote_index_top
// Fingerprint index: chained posting lists per landmark key plus vote store.
// ----------------------------------------------------------------------------
// After reset the block clears the key count and vote memories and takes no
// item until that pass ends. Insert and vote first read the key's count and
// first block; vote then reads each stored entry's value and counter and
// writes the counter back when the stored offset is not below the query. Clear
// sweeps the vote memory; report reads one counter per cycle over the first
// song_count songs (at most 64). One item is in work at a time; the result
// register lets the next item enter while a result waits to be taken.
module landmark_hash_vote_index_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // opcode, freq_anchor, freq_delta, time_delta, song_id, time_offset
    input  logic [39:0] s_axis_tdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // status, best_song, best_offset, best_count, zero fill
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [14:0] i_cfg_wdata
);

    lhv_pkg::t_state r_state, n_state;

    logic [14:0] r_max_blocks;
    logic [6:0]  r_song_count;
    logic [14:0] r_biu;
    logic [19:0] r_clr;

    logic [1:0]  r_op;
    logic [17:0] r_key;
    logic [5:0]  r_id;
    logic [13:0] r_q;

    logic [16:0] r_left;
    logic [13:0] r_blk;
    logic [3:0]  r_inblk;
    logic [2:0]  r_i;
    logic [19:0] r_vidx;

    logic [20:0] r_scan;
    logic        r_pv;
    logic [19:0] r_paddr;
    logic        r_have;
    logic [5:0]  r_best_song;
    logic [13:0] r_best_ofs;
    logic [14:0] r_best_cnt;
    logic        r_status;

    logic        r_ovalid;
    logic [39:0] r_odata;

    logic        w_accept;
    logic [17:0] w_in_key;

    logic        kc_we;
    logic [16:0] kc_wdata, kc_q;
    logic [17:0] kc_waddr;
    logic        kf_we;
    logic [13:0] kf_q;
    logic        lk_we;
    logic [13:0] lk_wdata, lk_q;
    logic        vl_we;
    logic [16:0] vl_waddr;
    logic [19:0] vl_q;
    logic        vt_we;
    logic [19:0] vt_waddr, vt_raddr;
    logic [14:0] vt_wdata, vt_q;

    logic [13:0] w_so;
    logic        w_hit;
    logic [19:0] w_idx;
    logic        w_last;
    logic [16:0] w_left_nxt;
    logic [6:0]  w_ns;
    logic        w_full;
    logic        w_need_blk;
    logic        w_pool_out;
    logic        w_ins_ok;
    logic [13:0] w_ins_blk;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_in_key = {s_axis_tdata[7:2], s_axis_tdata[13:8], s_axis_tdata[19:14]};
    assign s_axis_tready = (r_state == lhv_pkg::S_IDLE);

    assign w_full     = (kc_q == lhv_pkg::ENTRY_MAX);
    assign w_need_blk = (kc_q[2:0] == 3'd0);
    assign w_pool_out = (r_biu >= r_max_blocks) || r_biu[14];
    assign w_ins_ok   = (r_state == lhv_pkg::S_KRD) && (r_op == lhv_pkg::OP_INSERT)
                        && !w_full && !(w_need_blk && w_pool_out);
    assign w_ins_blk  = w_need_blk ? r_biu[13:0] : kf_q;

    assign w_so  = vl_q[13:0];
    assign w_hit = (w_so >= r_q);
    assign w_idx = {vl_q[19:14], w_so - r_q};
    assign w_last = ({1'b0, r_i} + 4'd1) == r_inblk;
    assign w_left_nxt = r_left - {13'd0, r_inblk};
    assign w_ns = (r_song_count > lhv_pkg::SONGS_MAX) ? lhv_pkg::SONGS_MAX : r_song_count;

    assign kc_we    = (r_state == lhv_pkg::S_INIT) || w_ins_ok;
    assign kc_waddr = (r_state == lhv_pkg::S_INIT) ? r_clr[17:0] : r_key;
    assign kc_wdata = (r_state == lhv_pkg::S_INIT) ? 17'd0 : kc_q + 17'd1;
    assign kf_we    = w_ins_ok && w_need_blk;
    assign lk_we    = kf_we;
    assign lk_wdata = (kc_q == 17'd0) ? 14'd0 : kf_q;
    assign vl_we    = w_ins_ok;
    assign vl_waddr = {w_ins_blk, kc_q[2:0]};

    assign vt_we    = (r_state == lhv_pkg::S_INIT) || (r_state == lhv_pkg::S_CLR)
                      || (r_state == lhv_pkg::S_VUP);
    assign vt_waddr = (r_state == lhv_pkg::S_VUP) ? r_vidx : r_clr;
    assign vt_wdata = (r_state == lhv_pkg::S_VUP) ?
                      ((vt_q == lhv_pkg::COUNT_MAX) ? vt_q : vt_q + 15'd1) : 15'd0;
    assign vt_raddr = (r_state == lhv_pkg::S_VQ) ? w_idx : r_scan[19:0];

    lhv_ram #(.AW(lhv_pkg::KEY_BITS), .DW(lhv_pkg::CNT_BITS)) u_key_cnt (
        .i_clk(i_clk), .i_we(kc_we), .i_waddr(kc_waddr), .i_wdata(kc_wdata),
        .i_raddr(w_in_key), .o_rdata(kc_q)
    );

    lhv_ram #(.AW(lhv_pkg::KEY_BITS), .DW(lhv_pkg::BLK_BITS)) u_key_first (
        .i_clk(i_clk), .i_we(kf_we), .i_waddr(r_key), .i_wdata(r_biu[13:0]),
        .i_raddr(w_in_key), .o_rdata(kf_q)
    );

    lhv_ram #(.AW(lhv_pkg::BLK_BITS), .DW(lhv_pkg::BLK_BITS)) u_link (
        .i_clk(i_clk), .i_we(lk_we), .i_waddr(r_biu[13:0]), .i_wdata(lk_wdata),
        .i_raddr(r_blk), .o_rdata(lk_q)
    );

    lhv_ram #(.AW(lhv_pkg::BLK_BITS + lhv_pkg::SLOT_BITS), .DW(lhv_pkg::VAL_BITS)) u_values (
        .i_clk(i_clk), .i_we(vl_we), .i_waddr(vl_waddr), .i_wdata({r_id, r_q}),
        .i_raddr({r_blk, r_i}), .o_rdata(vl_q)
    );

    lhv_ram #(.AW(lhv_pkg::VADDR_BITS), .DW(lhv_pkg::VOTE_BITS)) u_votes (
        .i_clk(i_clk), .i_we(vt_we), .i_waddr(vt_waddr), .i_wdata(vt_wdata),
        .i_raddr(vt_raddr), .o_rdata(vt_q)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            lhv_pkg::S_INIT: begin
                if (r_clr == 20'hFFFFF) n_state = lhv_pkg::S_IDLE;
            end
            lhv_pkg::S_IDLE: begin
                if (w_accept) begin
                    case (s_axis_tdata[1:0])
                        lhv_pkg::OP_CLEAR:  n_state = lhv_pkg::S_CLR;
                        lhv_pkg::OP_REPORT: n_state = lhv_pkg::S_RPT;
                        default:            n_state = lhv_pkg::S_KRD;
                    endcase
                end
            end
            lhv_pkg::S_KRD: begin
                if (r_op == lhv_pkg::OP_VOTE && kc_q != 17'd0) n_state = lhv_pkg::S_VRD;
                else n_state = lhv_pkg::S_OUT;
            end
            lhv_pkg::S_VRD: n_state = lhv_pkg::S_VQ;
            lhv_pkg::S_VQ: begin
                if (w_hit) n_state = lhv_pkg::S_VUP;
                else if (w_last && w_left_nxt == 17'd0) n_state = lhv_pkg::S_OUT;
                else n_state = lhv_pkg::S_VRD;
            end
            lhv_pkg::S_VUP: begin
                if (w_last && w_left_nxt == 17'd0) n_state = lhv_pkg::S_OUT;
                else n_state = lhv_pkg::S_VRD;
            end
            lhv_pkg::S_CLR: begin
                if (r_clr == 20'hFFFFF) n_state = lhv_pkg::S_OUT;
            end
            lhv_pkg::S_RPT: begin
                if (r_scan[20:14] == w_ns) n_state = lhv_pkg::S_RDRAIN;
            end
            lhv_pkg::S_RDRAIN: n_state = lhv_pkg::S_OUT;
            lhv_pkg::S_OUT: begin
                if (!r_ovalid || m_axis_tready) n_state = lhv_pkg::S_IDLE;
            end
            default: n_state = lhv_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lhv_pkg::S_INIT;
            r_max_blocks <= lhv_pkg::MAXB_RESET;
            r_song_count <= lhv_pkg::SONGS_RESET;
            r_biu        <= 15'd0;
            r_clr        <= 20'd0;
            r_ovalid     <= 1'b0;
            r_pv         <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_addr == lhv_pkg::CFG_MAX_BLOCKS) r_max_blocks <= i_cfg_wdata;
                else r_song_count <= i_cfg_wdata[6:0];
            end
            if (r_state == lhv_pkg::S_INIT || r_state == lhv_pkg::S_CLR) begin
                r_clr <= r_clr + 20'd1;
            end
            if (kf_we) r_biu <= r_biu + 15'd1;
            r_pv <= (r_state == lhv_pkg::S_RPT) && (r_scan[20:14] != w_ns);
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            if (r_state == lhv_pkg::S_OUT && (!r_ovalid || m_axis_tready)) r_ovalid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= s_axis_tdata[1:0];
            r_key    <= w_in_key;
            r_id     <= s_axis_tdata[25:20];
            r_q      <= s_axis_tdata[39:26];
            r_scan   <= 21'd0;
            r_have   <= 1'b0;
            r_status <= 1'b0;
            r_best_song <= 6'd0;
            r_best_ofs  <= 14'd0;
            r_best_cnt  <= 15'd0;
        end
        if (r_state == lhv_pkg::S_KRD) begin
            if (r_op == lhv_pkg::OP_INSERT) r_status <= !w_ins_ok;
            r_left  <= kc_q;
            r_blk   <= kf_q;
            r_inblk <= {1'b0, kc_q[2:0] - 3'd1} + 4'd1;
            r_i     <= 3'd0;
        end
        if (r_state == lhv_pkg::S_VQ) r_vidx <= w_idx;
        if ((r_state == lhv_pkg::S_VQ && !w_hit) || r_state == lhv_pkg::S_VUP) begin
            if (w_last) begin
                r_left  <= w_left_nxt;
                r_blk   <= lk_q;
                r_inblk <= 4'd8;
                r_i     <= 3'd0;
            end else begin
                r_i <= r_i + 3'd1;
            end
        end
        if (r_state == lhv_pkg::S_RPT && r_scan[20:14] != w_ns) begin
            r_scan <= r_scan + 21'd1;
        end
        r_paddr <= r_scan[19:0];
        if (r_pv && (!r_have || vt_q > r_best_cnt)) begin
            r_have      <= 1'b1;
            r_best_cnt  <= vt_q;
            r_best_song <= r_paddr[19:14];
            r_best_ofs  <= r_paddr[13:0];
        end
        if (r_state == lhv_pkg::S_OUT && (!r_ovalid || m_axis_tready)) begin
            if (r_op == lhv_pkg::OP_REPORT) begin
                r_odata <= {4'd0, r_best_cnt, r_best_ofs, r_best_song, 1'b0};
            end else begin
                r_odata <= {39'd0, r_status && (r_op == lhv_pkg::OP_INSERT)};
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule

### verif/lhv_index_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhv_index_checker
// Watches the item, result and register channels of the landmark hash index,
// keeps its own copy of the posting lists, pool and vote store, predicts one
// result per accepted item and compares each taken result field by field.
// ----------------------------------------------------------------------------
module lhv_index_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [39:0] i_in_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [39:0] i_out_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [14:0] i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int BLOCK_SIZE  = 8;
    localparam int POOL_BLOCKS = 16384;

    typedef struct {
        logic        status;
        logic [5:0]  song;
        logic [13:0] ofs;
        logic [14:0] cnt;
    } t_match;

    t_match       match_queue[$];
    int unsigned  key_len[int];
    int unsigned  key_head[int];
    int unsigned  blk_link[POOL_BLOCKS];
    logic [19:0]  blk_vals[POOL_BLOCKS*BLOCK_SIZE];
    int unsigned  pool_used;
    int unsigned  tally[int];
    logic [14:0]  max_blocks;
    logic [6:0]   song_count;
    int           fails;

    function automatic logic add_landmark(int key, logic [5:0] sid, logic [13:0] ofs);
        int unsigned n;
        int unsigned slot;
        int unsigned blk;
        n = key_len.exists(key) ? key_len[key] : 0;
        slot = n % BLOCK_SIZE;
        if (n >= lhv_pkg::ENTRY_MAX) return 1'b1;
        if (slot == 0) begin
            if (pool_used >= max_blocks || pool_used >= POOL_BLOCKS) return 1'b1;
            blk = pool_used;
            pool_used++;
            blk_link[blk] = (n == 0) ? 0 : key_head[key];
            key_head[key] = blk;
        end
        blk = key_head[key] % POOL_BLOCKS;
        blk_vals[blk*BLOCK_SIZE + slot] = {sid, ofs};
        key_len[key] = n + 1;
        return 1'b0;
    endfunction

    function automatic void cast_votes(int key, int unsigned q);
        int unsigned left;
        int unsigned blk;
        int unsigned inblk;
        int unsigned so;
        int          idx;
        logic [19:0] v;
        left = key_len.exists(key) ? key_len[key] : 0;
        if (left == 0) return;
        blk = key_head[key] % POOL_BLOCKS;
        inblk = ((left - 1) % BLOCK_SIZE) + 1;
        while (left != 0) begin
            for (int i = 0; i < inblk; i++) begin
                v = blk_vals[blk*BLOCK_SIZE + i];
                so = v[13:0];
                if (so >= q) begin
                    idx = (int'(v[19:14]) << lhv_pkg::OFS_BITS) | int'(so - q);
                    if (!tally.exists(idx)) tally[idx] = 1;
                    else if (tally[idx] < lhv_pkg::COUNT_MAX) tally[idx]++;
                end
            end
            left -= inblk;
            inblk = BLOCK_SIZE;
            blk = blk_link[blk] % POOL_BLOCKS;
        end
    endfunction

    function automatic t_match predict_match(logic [39:0] d);
        t_match      r;
        int          key;
        int unsigned ns;
        int unsigned best;
        r = '{1'b0, 6'd0, 14'd0, 15'd0};
        key = {d[7:2], d[13:8], d[19:14]};
        case (d[1:0])
            lhv_pkg::OP_INSERT: r.status = add_landmark(key, d[25:20], d[39:26]);
            lhv_pkg::OP_VOTE:   cast_votes(key, d[39:26]);
            lhv_pkg::OP_CLEAR:  tally.delete();
            lhv_pkg::OP_REPORT: begin
                ns = (song_count < lhv_pkg::SONGS_MAX) ? song_count : lhv_pkg::SONGS_MAX;
                best = 0;
                if (ns != 0) begin
                    foreach (tally[idx]) begin
                        if (idx < (ns << lhv_pkg::OFS_BITS) && tally[idx] > best) begin
                            best = tally[idx];
                            r.song = 6'(idx >> lhv_pkg::OFS_BITS);
                            r.ofs = 14'(idx);
                        end
                    end
                end
                r.cnt = 15'(best);
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_match e;
        if (!i_rst_n) begin
            match_queue.delete();
            key_len.delete();
            key_head.delete();
            tally.delete();
            pool_used = 0;
            max_blocks = lhv_pkg::MAXB_RESET;
            song_count = lhv_pkg::SONGS_RESET;
            fails = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    lhv_pkg::CFG_MAX_BLOCKS: max_blocks = i_cfg_wdata;
                    lhv_pkg::CFG_SONG_COUNT: song_count = i_cfg_wdata[6:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (match_queue.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected result %h", i_out_data);
                end else begin
                    e = match_queue.pop_front();
                    if (i_out_data[0] !== e.status || i_out_data[6:1] !== e.song ||
                        i_out_data[20:7] !== e.ofs || i_out_data[35:21] !== e.cnt ||
                        i_out_data[39:36] !== 4'd0) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: exp st=%0d song=%0d ofs=%0d cnt=%0d got %h",
                                     e.status, e.song, e.ofs, e.cnt, i_out_data);
                    end
                end
            end
            if (i_in_valid && i_in_ready) match_queue.push_back(predict_match(i_in_data));
        end
        o_fail_count <= fails;
        o_pending <= match_queue.size();
    end

endmodule

### verif/landmark_hash_vote_index_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// landmark_hash_vote_index_top_tb
// Drives directed insert, vote, clear and report items and random insert,
// vote and report items into the index under varying idle patterns and
// register settings; the checker's fail and pending counts give the verdict.
// ----------------------------------------------------------------------------
module landmark_hash_vote_index_top_tb;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic [39:0] s_axis_tdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_addr = 1'b0;
    logic [14:0] i_cfg_wdata = '0;
    int          fail_count;
    int          pending;
    int          tx_idle = 38;
    int          rx_idle = 51;
    int          hold_req = 0;
    int          hold_ack = 0;
    int          hold_left = 0;
    logic [17:0] key_pool[12];

    landmark_hash_vote_index_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tdata(s_axis_tdata), .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata)
    );

    lhv_index_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_data(s_axis_tdata), .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #400ms;
        $display("FAIL landmark_hash_vote_index_top");
        $finish;
    end

    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_left <= 3000;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle);
        end
    end

    function automatic logic [39:0] pack_item(logic [1:0] op, logic [17:0] key,
                                              logic [5:0] sid, logic [13:0] ofs);
        return {ofs, sid, key[5:0], key[11:6], key[17:12], op};
    endfunction

    task automatic send_item(logic [39:0] d);
        if ($urandom_range(99) < tx_idle) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (32) @(posedge i_clk);
    endtask

    task automatic write_reg(logic addr, logic [14:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_random();
        int          r;
        logic [17:0] key;
        logic [5:0]  sid;
        logic [13:0] ofs;
        r = $urandom_range(99);
        key = ($urandom_range(9) == 0) ? 18'($urandom) : key_pool[$urandom_range(11)];
        sid = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(3));
        ofs = ($urandom_range(7) == 0) ? 14'($urandom_range(16383)) : 14'($urandom_range(200));
        if (r < 50) send_item(pack_item(lhv_pkg::OP_INSERT, key, sid, ofs));
        else if (r < 97) send_item(pack_item(lhv_pkg::OP_VOTE, key, 6'($urandom), ofs));
        else send_item(pack_item(lhv_pkg::OP_REPORT, 18'($urandom), 6'($urandom),
                                 14'($urandom)));
    endtask

    task automatic run_random(int count, int tx, int rx, int hold_at);
        tx_idle = tx;
        rx_idle = rx;
        for (int i = 0; i < count; i++) begin
            if (i == hold_at) hold_req <= hold_req + 1;
            send_random();
        end
        drain_results();
    endtask

    initial begin
        logic [17:0] k_hi;
        logic [17:0] k_sat;
        k_hi = '1;
        k_sat = 18'h01083;
        foreach (key_pool[i]) key_pool[i] = 18'($urandom);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);

        write_reg(lhv_pkg::CFG_MAX_BLOCKS, lhv_pkg::MAXB_RESET);
        write_reg(lhv_pkg::CFG_SONG_COUNT, 15'd100);
        send_item(pack_item(lhv_pkg::OP_REPORT, 18'd0, 6'd0, 14'd0));
        send_item(pack_item(lhv_pkg::OP_INSERT, k_hi, 6'd63, 14'h3FFF));
        send_item(pack_item(lhv_pkg::OP_INSERT, k_hi, 6'd0, 14'd0));
        send_item(pack_item(lhv_pkg::OP_INSERT, 18'd0, 6'd63, 14'd0));
        send_item(pack_item(lhv_pkg::OP_INSERT, 18'd0, 6'd1, 14'h3FFF));
        send_item(pack_item(lhv_pkg::OP_VOTE, k_hi, 6'd0, 14'd0));
        send_item(pack_item(lhv_pkg::OP_VOTE, k_hi, 6'd0, 14'h3FFF));
        send_item(pack_item(lhv_pkg::OP_VOTE, 18'd0, 6'd0, 14'd0));
        send_item(pack_item(lhv_pkg::OP_VOTE, 18'd1, 6'd0, 14'd5));
        drain_results();
        write_reg(lhv_pkg::CFG_SONG_COUNT, 15'd0);
        send_item(pack_item(lhv_pkg::OP_REPORT, 18'd0, 6'd0, 14'd0));
        drain_results();
        write_reg(lhv_pkg::CFG_SONG_COUNT, 15'd2);
        send_item(pack_item(lhv_pkg::OP_REPORT, 18'd0, 6'd0, 14'd0));
        send_item(pack_item(lhv_pkg::OP_CLEAR, 18'd0, 6'd0, 14'd0));
        send_item(pack_item(lhv_pkg::OP_REPORT, 18'd0, 6'd0, 14'd0));
        drain_results();
        write_reg(lhv_pkg::CFG_MAX_BLOCKS, 15'd1);
        send_item(pack_item(lhv_pkg::OP_INSERT, 18'h2AAAA, 6'd7, 14'd9));
        send_item(pack_item(lhv_pkg::OP_INSERT, k_hi, 6'd1, 14'd20));
        send_item(pack_item(lhv_pkg::OP_INSERT, 18'd0, 6'd1, 14'd30));
        send_item(pack_item(lhv_pkg::OP_VOTE, k_hi, 6'd0, 14'd0));
        send_item(pack_item(lhv_pkg::OP_REPORT, 18'd0, 6'd0, 14'd0));
        drain_results();

        // saturate one vote counter
        write_reg(lhv_pkg::CFG_MAX_BLOCKS, lhv_pkg::MAXB_RESET);
        write_reg(lhv_pkg::CFG_SONG_COUNT, 15'd6);
        tx_idle = 38;
        rx_idle = 51;
        repeat (256) send_item(pack_item(lhv_pkg::OP_INSERT, k_sat, 6'd5, 14'd100));
        repeat (130) send_item(pack_item(lhv_pkg::OP_VOTE, k_sat, 6'd0, 14'd100));
        send_item(pack_item(lhv_pkg::OP_REPORT, 18'd0, 6'd0, 14'd0));
        drain_results();

        write_reg(lhv_pkg::CFG_SONG_COUNT, 15'd3);
        run_random(250, 38, 51, -1);
        write_reg(lhv_pkg::CFG_MAX_BLOCKS, 15'($urandom_range(60, 120)));
        write_reg(lhv_pkg::CFG_SONG_COUNT, 15'd2);
        run_random(380, 51, 38, 100);
        write_reg(lhv_pkg::CFG_MAX_BLOCKS, lhv_pkg::MAXB_RESET);
        write_reg(lhv_pkg::CFG_SONG_COUNT, 15'd1);
        run_random(380, 0, 0, -1);

        if (fail_count == 0 && pending == 0) begin
            $display("PASS landmark_hash_vote_index_top");
        end else begin
            $display("FAIL landmark_hash_vote_index_top");
        end
        $finish;
    end

endmodule
